>>> rtl/vic_pkg.sv
// Shared types and constants for the vectored interrupt controller.
// Depends on nothing; every other file of the block imports it.
package vic_pkg;

   // Fixed field widths of the transfer payloads.
   localparam int OPCODE_W = 3;
   localparam int SOURCE_W = 6;
   localparam int VECTOR_W = 32;
   localparam int LINES_W  = 64;
   localparam int STATUS_W = 2;

   // Defaults for the top-level parameters.
   localparam int DEFAULT_NUM_SOURCES = 64;
   localparam int DEFAULT_VECTOR_BITS = 32;

   // Command codes.
   localparam logic [OPCODE_W-1:0] OP_REQUEST  = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_FREE     = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_CLAIM    = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_MASK     = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_COMPLETE = 3'd4;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO_VECTOR = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_REG     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NONE_PEND   = 2'd3;

   // Command payload.
   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [SOURCE_W-1:0] source;
      logic [VECTOR_W-1:0] handler_vector;
      logic [LINES_W-1:0]  raw_lines;
   } vic_req_type;

   // Result payload.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SOURCE_W-1:0] claimed_source;
      logic [VECTOR_W-1:0] claimed_vector;
      logic [LINES_W-1:0]  enable_mask;
   } vic_rsp_type;

endpackage

>>> rtl/vectored_interrupt_controller_unit.sv
// Vectored interrupt controller top level: a command register, one pass of decode logic,
// and a result register. A command is held in the command register after its transfer and
// moves to the result register when that is free or drained; the result transfers from there.
// Throughput: one command per cycle while the receiver does not stall.
// Reset clears enable bits, registration bits and both valid flags at once; no clearing
// pass is needed since a vector reads as zero while its registration bit is clear.
module vectored_interrupt_controller_unit import vic_pkg::*; #(
   parameter int NUM_SOURCES = DEFAULT_NUM_SOURCES,
   parameter int VECTOR_BITS = DEFAULT_VECTOR_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  vic_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output vic_rsp_type rsp_data
);

   localparam int IDX_W  = $clog2(NUM_SOURCES);
   localparam int COPY_W = (VECTOR_BITS < VECTOR_W) ? VECTOR_BITS : VECTOR_W;
   localparam logic [SOURCE_W:0] NUM_SRC_C = (SOURCE_W + 1)'(NUM_SOURCES);
   localparam logic [NUM_SOURCES-1:0] ONE_BIT = NUM_SOURCES'(1);

   // Command stage.
   logic        s_valid_ff, s_valid_in;
   vic_req_type s_ff;
   logic        req_take;
   logic        out_load;

   // Interrupt state.
   logic [NUM_SOURCES-1:0] enable_ff, enable_in;
   logic [NUM_SOURCES-1:0] flag_ff, flag_in;

   // Result stage.
   logic                   o_valid_ff, o_valid_in;
   logic [STATUS_W-1:0]    o_status_ff, o_status_in;
   logic [SOURCE_W-1:0]    o_src_ff, o_src_in;
   logic [NUM_SOURCES-1:0] o_en_ff;
   logic                   o_vec_ok_ff, o_vec_ok_in;

   // Decode signals.
   logic                   in_range;
   logic [NUM_SOURCES-1:0] src_bit;
   logic                   flag_src;
   logic [VECTOR_BITS-1:0] wr_vec;
   logic                   vec_zero;
   logic [NUM_SOURCES-1:0] pend;
   logic                   found;
   logic [IDX_W-1:0]       enc_idx;
   logic [NUM_SOURCES-1:0] claim_bit;
   logic                   grant;
   logic                   wr_en;
   logic [VECTOR_BITS-1:0] rd_vec;

   // Handshake: the command stage moves on whenever the result register is free or drained.
   assign out_load   = s_valid_ff && (!o_valid_ff || !rsp_stall);
   assign req_stall  = s_valid_ff && !out_load;
   assign req_take   = req_valid && !req_stall;
   assign s_valid_in = req_take ? 1'b1 : (out_load ? 1'b0 : s_valid_ff);
   assign o_valid_in = out_load ? 1'b1 : ((o_valid_ff && !rsp_stall) ? 1'b0 : o_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= s_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   // Command register captures the payload of each input transfer.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s_ff <= req_data;
      end
   end

   // Source lookup and vector trimming.
   assign in_range = {1'b0, s_ff.source} < NUM_SRC_C;
   assign src_bit  = ONE_BIT << s_ff.source;
   assign flag_src = |(flag_ff & src_bit);

   always_comb begin
      wr_vec = '0;
      wr_vec[COPY_W-1:0] = s_ff.handler_vector[COPY_W-1:0];
   end

   assign vec_zero = (wr_vec == '0);

   // Pending set and lowest pending source for a claim.
   assign pend = s_ff.raw_lines[NUM_SOURCES-1:0] & enable_ff;

   vic_prio_enc #(
      .WIDTH (NUM_SOURCES),
      .IDX_W (IDX_W)
   ) u_prio_enc (
      .pend  (pend),
      .found (found),
      .index (enc_idx)
   );

   assign claim_bit = ONE_BIT << enc_idx;

   // Command decode and next state.
   always_comb begin
      enable_in   = enable_ff;
      flag_in     = flag_ff;
      o_status_in = ST_OK;
      grant       = 1'b0;
      wr_en       = 1'b0;
      unique case (s_ff.opcode)
         OP_REQUEST: begin
            if (!in_range) begin
               o_status_in = ST_NOT_REG;
            end else if (vec_zero) begin
               o_status_in = ST_ZERO_VECTOR;
            end else begin
               wr_en     = 1'b1;
               enable_in = enable_ff | src_bit;
               flag_in   = flag_ff | src_bit;
            end
         end
         OP_FREE: begin
            if (!in_range || !flag_src) begin
               o_status_in = ST_NOT_REG;
            end else begin
               enable_in = enable_ff & ~src_bit;
               flag_in   = flag_ff & ~src_bit;
            end
         end
         OP_CLAIM: begin
            if (!found) begin
               o_status_in = ST_NONE_PEND;
            end else begin
               grant     = 1'b1;
               enable_in = enable_ff & ~claim_bit;
            end
         end
         OP_MASK: begin
            if (in_range) begin
               enable_in = enable_ff & ~src_bit;
            end
         end
         OP_COMPLETE: begin
            if (!in_range) begin
               o_status_in = ST_NOT_REG;
            end else begin
               enable_in = enable_ff | src_bit;
               if (!flag_src) begin
                  o_status_in = ST_NOT_REG;
               end
            end
         end
         default: begin
            o_status_in = ST_OK;
         end
      endcase
   end

   assign o_src_in    = grant ? SOURCE_W'(enc_idx) : '0;
   assign o_vec_ok_in = grant && |(flag_ff & claim_bit);

   // Enable and registration bits update as each command leaves the stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
         flag_ff   <= '0;
      end else if (out_load) begin
         enable_ff <= enable_in;
         flag_ff   <= flag_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (out_load) begin
         o_status_ff <= o_status_in;
         o_src_ff    <= o_src_in;
         o_en_ff     <= enable_in;
         o_vec_ok_ff <= o_vec_ok_in;
      end
   end

   // Vector memory: written by request, read at the granted source by claim.
   vic_vector_ram #(
      .DEPTH  (NUM_SOURCES),
      .WIDTH  (VECTOR_BITS),
      .ADDR_W (IDX_W)
   ) u_vector_ram (
      .clock   (clock),
      .wr_en   (out_load && wr_en),
      .wr_addr (s_ff.source[IDX_W-1:0]),
      .wr_data (wr_vec),
      .rd_en   (out_load && grant),
      .rd_addr (enc_idx),
      .rd_data (rd_vec)
   );

   // Result payload.
   assign rsp_valid = o_valid_ff;

   always_comb begin
      rsp_data                = '0;
      rsp_data.status         = o_status_ff;
      rsp_data.claimed_source = o_src_ff;
      rsp_data.enable_mask    = LINES_W'(o_en_ff);
      if (o_vec_ok_ff) begin
         rsp_data.claimed_vector[COPY_W-1:0] = rd_vec[COPY_W-1:0];
      end
   end

`ifndef SYNTHESIS
   // A granted source is masked once the claim has taken effect.
   a_claim_masks: assert property (@(posedge clock) disable iff (reset)
      (out_load && grant) |=> ((enable_ff & $past(claim_bit)) == '0))
      else $error("claimed source still enabled");

   // A stored vector leaves its source registered and enabled.
   a_request_registers: assert property (@(posedge clock) disable iff (reset)
      (out_load && wr_en) |=> (((flag_ff & enable_ff) & $past(src_bit)) != '0))
      else $error("request did not register source");

   // With nothing pending, no source or vector is reported.
   a_none_pending_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_NONE_PEND) |->
      (rsp_data.claimed_source == '0 && rsp_data.claimed_vector == '0))
      else $error("grant reported with empty pending set");
`endif

endmodule

>>> rtl/vic_prio_enc.sv
// Lowest-set-bit priority encoder used by the claim command.
// Depends on vic_pkg for the default width.
module vic_prio_enc import vic_pkg::*; #(
   parameter int WIDTH = DEFAULT_NUM_SOURCES,
   parameter int IDX_W = $clog2(WIDTH)
) (
   input  logic [WIDTH-1:0] pend,
   output logic             found,
   output logic [IDX_W-1:0] index
);

   logic [WIDTH-1:0] low_bit;

   // Isolate the lowest pending bit with a two's complement trick.
   assign low_bit = pend & (~pend + WIDTH'(1));
   assign found   = |pend;

   // Each index bit is the OR of the one-hot positions that carry it.
   always_comb begin
      index = '0;
      for (int b = 0; b < IDX_W; b++) begin
         for (int n = 0; n < WIDTH; n++) begin
            if (n[b]) begin
               index[b] = index[b] | low_bit[n];
            end
         end
      end
   end

endmodule

>>> rtl/vic_vector_ram.sv
// Handler vector memory: one write port, one read port with registered data.
// Depends on vic_pkg for the default sizes.
module vic_vector_ram import vic_pkg::*; #(
   parameter int DEPTH  = DEFAULT_NUM_SOURCES,
   parameter int WIDTH  = DEFAULT_VECTOR_BITS,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data register holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> test/tb_top.sv
// Self-checking regression for vectored_interrupt_controller_unit: a directed opening,
// then random command phases with receiver hold-off, full-rate and drained pauses.
// Depends on vic_pkg and the controller RTL.
module tb_top;
   import vic_pkg::*;

   // The block is built with its default source count and vector width.
   localparam int NUM_SRC = DEFAULT_NUM_SOURCES;
   localparam int VEC_BITS = DEFAULT_VECTOR_BITS;
   localparam logic [LINES_W-1:0] SOURCE_KEEP =
      (NUM_SRC >= LINES_W) ? {LINES_W{1'b1}} : ((64'd1 << NUM_SRC) - 64'd1);
   localparam logic [VECTOR_W-1:0] VECTOR_KEEP =
      (VEC_BITS >= VECTOR_W) ? {VECTOR_W{1'b1}} : ((32'd1 << VEC_BITS) - 32'd1);

   // Opcodes that the block decodes as no operation.
   localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_SPARE_MID = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

   localparam int IDLE_PERCENT = 21;
   localparam int LONG_HOLD = 150;
   localparam int REPORT_LIMIT = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   vic_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   vic_rsp_type rsp_data;

   // Commands waiting to be driven and replies waiting to arrive.
   vic_req_type command_queue[$];
   vic_rsp_type predicted_replies[$];

   // Predictor copy of the enable bits and the handler table.
   logic [LINES_W-1:0] model_enable = '0;
   logic [VECTOR_W-1:0] model_vectors [LINES_W] = '{default: '0};

   logic req_fire = 1'b0;
   bit no_gaps = 1'b0;
   int unsigned hold_ticket = 0;
   int unsigned hold_ticket_seen = 0;
   int hold_left = 0;
   int unsigned error_count = 0;
   int unsigned mismatch_count = 0;

   vectored_interrupt_controller_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Random idle decision shared by both sides.
   function automatic bit gap_roll();
      return !no_gaps && ($urandom_range(99) < IDLE_PERCENT);
   endfunction

   // Applies one command to the predictor state and returns the reply it should produce.
   function automatic vic_rsp_type next_vic_reply(vic_req_type cmd);
      vic_rsp_type reply;
      logic [VECTOR_W-1:0] vec;
      logic [LINES_W-1:0] pend;
      logic in_range;
      int lowest;
      reply = '0;
      vec = cmd.handler_vector & VECTOR_KEEP;
      in_range = (int'(cmd.source) < NUM_SRC);
      lowest = 0;
      case (cmd.opcode)
         OP_REQUEST: begin
            if (!in_range) begin
               reply.status = ST_NOT_REG;
            end else if (vec == '0) begin
               reply.status = ST_ZERO_VECTOR;
            end else begin
               model_vectors[cmd.source] = vec;
               model_enable[cmd.source] = 1'b1;
            end
         end
         OP_FREE: begin
            if (!in_range || model_vectors[cmd.source] == '0) begin
               reply.status = ST_NOT_REG;
            end else begin
               model_enable[cmd.source] = 1'b0;
               model_vectors[cmd.source] = '0;
            end
         end
         OP_CLAIM: begin
            pend = cmd.raw_lines & model_enable & SOURCE_KEEP;
            if (pend == '0) begin
               reply.status = ST_NONE_PEND;
            end else begin
               // Scan downward so that the last hit is the lowest pending source.
               for (int n = LINES_W - 1; n >= 0; n--) begin
                  if (pend[n]) lowest = n;
               end
               model_enable[lowest] = 1'b0;
               reply.claimed_source = lowest[SOURCE_W-1:0];
               reply.claimed_vector = model_vectors[lowest];
            end
         end
         OP_MASK: begin
            if (in_range) model_enable[cmd.source] = 1'b0;
         end
         OP_COMPLETE: begin
            if (!in_range) begin
               reply.status = ST_NOT_REG;
            end else begin
               model_enable[cmd.source] = 1'b1;
               if (model_vectors[cmd.source] == '0) reply.status = ST_NOT_REG;
            end
         end
         default: begin
         end
      endcase
      model_enable &= SOURCE_KEEP;
      reply.enable_mask = model_enable;
      return reply;
   endfunction

   function automatic void push_cmd(logic [OPCODE_W-1:0] op, int unsigned src,
                                    logic [VECTOR_W-1:0] vec, logic [LINES_W-1:0] lines);
      vic_req_type cmd;
      cmd.opcode = op;
      cmd.source = src[SOURCE_W-1:0];
      cmd.handler_vector = vec;
      cmd.raw_lines = lines;
      command_queue.push_back(cmd);
   endfunction

   // Random command biased toward sources around the bank boundary so state gets reused.
   function automatic vic_req_type random_command();
      vic_req_type cmd;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 22) cmd.opcode = OP_REQUEST;
      else if (pick < 32) cmd.opcode = OP_FREE;
      else if (pick < 62) cmd.opcode = OP_CLAIM;
      else if (pick < 72) cmd.opcode = OP_MASK;
      else if (pick < 96) cmd.opcode = OP_COMPLETE;
      else cmd.opcode = OP_SPARE_LO + 3'($urandom_range(2));
      if ($urandom_range(1) == 0) cmd.source = SOURCE_W'($urandom_range(35, 28));
      else cmd.source = SOURCE_W'($urandom());
      cmd.handler_vector = $urandom();
      if ($urandom_range(19) == 0) cmd.handler_vector = '0;
      case ($urandom_range(3))
         0: cmd.raw_lines = {$urandom(), $urandom()};
         1: cmd.raw_lines = (64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63));
         2: cmd.raw_lines = {LINES_W{1'b1}};
         default: cmd.raw_lines = {$urandom(), $urandom()} & {$urandom(), $urandom()};
      endcase
      return cmd;
   endfunction

   // Sender: a held command stays on the bus until its transfer completes.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (command_queue.size() != 0 && !gap_roll()) begin
            req_data <= command_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever a new ticket is issued.
   always @(negedge clock) begin
      if (hold_ticket_seen != hold_ticket) begin
         hold_ticket_seen = hold_ticket;
         hold_left = LONG_HOLD;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= gap_roll();
      end
   end

   // Monitor: check the reply transfer first, then predict for the command transfer.
   always @(posedge clock) begin : monitor
      vic_rsp_type want;
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_replies.size() == 0) begin
               error_count++;
               $display("unexpected reply: status=%0d source=%0d vector=%h mask=%h",
                        rsp_data.status, rsp_data.claimed_source,
                        rsp_data.claimed_vector, rsp_data.enable_mask);
            end else begin
               want = predicted_replies.pop_front();
               if (rsp_data.status !== want.status
                   || rsp_data.claimed_source !== want.claimed_source
                   || rsp_data.claimed_vector !== want.claimed_vector
                   || rsp_data.enable_mask !== want.enable_mask) begin
                  error_count++;
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("mismatch: status %0d/%0d source %0d/%0d vector %h/%h mask %h/%h",
                              want.status, rsp_data.status,
                              want.claimed_source, rsp_data.claimed_source,
                              want.claimed_vector, rsp_data.claimed_vector,
                              want.enable_mask, rsp_data.enable_mask);
                  end
               end
            end
         end
         if (req_valid && !req_stall) predicted_replies.push_back(next_vic_reply(req_data));
      end
   end

   // Waits until every queued command has been transferred and every reply has come.
   task automatic wait_drained();
      @(negedge clock);
      while (command_queue.size() != 0 || predicted_replies.size() != 0 || req_valid) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic queue_random(int unsigned count);
      repeat (count) command_queue.push_back(random_command());
   endtask

   // Stimulus and end of run.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening: edge values, every opcode and the special cases.
      push_cmd(OP_CLAIM, 0, '0, {LINES_W{1'b1}});
      push_cmd(OP_REQUEST, 0, '0, '0);
      push_cmd(OP_REQUEST, 0, {VECTOR_W{1'b1}}, '0);
      push_cmd(OP_REQUEST, 63, 32'h0000_0001, '0);
      push_cmd(OP_REQUEST, 32, 32'h8000_0000, '0);
      push_cmd(OP_CLAIM, 0, '0, {LINES_W{1'b1}});
      push_cmd(OP_CLAIM, 0, '0, {LINES_W{1'b1}});
      push_cmd(OP_CLAIM, 0, '0, 64'h8000_0000_0000_0000);
      push_cmd(OP_CLAIM, 0, '0, {LINES_W{1'b1}});
      push_cmd(OP_COMPLETE, 0, '0, '0);
      // Completing an unregistered source still enables it; a claim then grants it.
      push_cmd(OP_COMPLETE, 5, '0, '0);
      push_cmd(OP_CLAIM, 0, '0, 64'h0000_0000_0000_0020);
      push_cmd(OP_MASK, 0, '0, '0);
      push_cmd(OP_MASK, 40, '0, '0);
      // Bank 0 wins over bank 1 when both have a pending source.
      push_cmd(OP_REQUEST, 31, 32'h5555_aaaa, '0);
      push_cmd(OP_COMPLETE, 32, '0, '0);
      push_cmd(OP_CLAIM, 0, '0, 64'h0000_0001_8000_0000);
      push_cmd(OP_CLAIM, 0, '0, 64'h0000_0001_8000_0000);
      push_cmd(OP_FREE, 63, '0, '0);
      push_cmd(OP_FREE, 63, '0, '0);
      push_cmd(OP_FREE, 7, '0, '0);
      push_cmd(OP_CLAIM, 0, '0, '0);
      push_cmd(OP_SPARE_LO, 9, 32'hdead_beef, {LINES_W{1'b1}});
      push_cmd(OP_SPARE_MID, 0, '0, '0);
      push_cmd(OP_SPARE_HI, 63, {VECTOR_W{1'b1}}, {LINES_W{1'b1}});
      wait_drained();

      // Random traffic with the usual idling on both sides.
      queue_random(500);
      wait_drained();

      // Receiver holds off for a long stretch while the sender keeps offering commands.
      hold_ticket++;
      queue_random(300);
      wait_drained();

      // Full rate on both sides.
      no_gaps = 1'b1;
      queue_random(400);
      wait_drained();
      no_gaps = 1'b0;

      queue_random(250);
      wait_drained();
      repeat (4) @(posedge clock);

      error_count += predicted_replies.size();
      if (error_count == 0) begin
         $display("vectored_interrupt_controller_unit regression: pass");
      end else begin
         $display("vectored_interrupt_controller_unit regression: fail");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #400000;
      $display("vectored_interrupt_controller_unit regression: fail");
      $finish;
   end

endmodule

>>> sim.f
rtl/vic_pkg.sv
rtl/vic_prio_enc.sv
rtl/vic_vector_ram.sv
rtl/vectored_interrupt_controller_unit.sv
test/tb_top.sv
